// ===== rtl/tbd_pkg.sv =====
// ----------------------------------------------------------------------------
// tbd_pkg: shared types and constants of the time bucket downsampler
// Field widths, register indexes, aggregate codes and the bucket
// accumulator interface structs.
// ----------------------------------------------------------------------------
package tbd_pkg;

    localparam int TIME_W  = 48;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 56;
    localparam int COUNT_W = 24;
    localparam int INDEX_W = 16;
    localparam int EMIT_W  = 17;
    localparam int IV_W    = 32;
    localparam int FUNC_W  = 3;

    // Serial divider: one quotient bit per cycle over the full dividend
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration register indexes
    localparam logic [1:0] REG_INTERVAL = 2'd0;
    localparam logic [1:0] REG_FUNC     = 2'd1;
    localparam logic [1:0] REG_MAX_OUT  = 2'd2;

    // Aggregate selector codes (any other code averages)
    localparam logic [FUNC_W-1:0] AGG_AVG   = 3'd0;
    localparam logic [FUNC_W-1:0] AGG_MIN   = 3'd1;
    localparam logic [FUNC_W-1:0] AGG_MAX   = 3'd2;
    localparam logic [FUNC_W-1:0] AGG_SUM   = 3'd3;
    localparam logic [FUNC_W-1:0] AGG_FIRST = 3'd4;
    localparam logic [FUNC_W-1:0] AGG_LAST  = 3'd5;
    localparam logic [FUNC_W-1:0] AGG_COUNT = 3'd6;

    localparam logic [IV_W-1:0]    INTERVAL_RESET = 32'd60000;
    localparam logic [INDEX_W-1:0] MAX_OUT_RESET  = 16'hFFFF;

    localparam logic [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic clear;   // zero the sum and the sample count
        logic add;     // fold one sample into the bucket
    } acc_ctrl_t;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] head_val;
        logic [VALUE_W-1:0] tail_val;
        logic [VALUE_W-1:0] min_val;
        logic [VALUE_W-1:0] max_val;
    } acc_stat_t;

endpackage

// ===== rtl/tbd_divider.sv =====
// ----------------------------------------------------------------------------
// tbd_divider: bit-serial restoring divider
// Shifts the dividend out one bit per cycle into a narrow remainder and
// shifts the quotient bits back into the same register; pulses done
// once the last step is through.
// ----------------------------------------------------------------------------
module tbd_divider
    import tbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [SUM_W-1:0]   dividend,
    input  logic [IV_W-1:0]    divisor,
    output logic               busy,
    output logic               done,
    output logic [SUM_W-1:0]   quotient,
    output logic [IV_W-1:0]    remainder
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]     shift_reg, shift_next;
    logic [IV_W-1:0]      rem_reg, rem_next;
    logic [IV_W-1:0]      dvs_reg, dvs_next;

    logic [IV_W:0] trial;
    logic [IV_W:0] diff;
    logic          fits;

    // One restoring step: bring in the next dividend bit, try a subtract
    assign trial = {rem_reg, shift_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
        end else if (busy_reg) begin
            shift_next = {shift_reg[SUM_W-2:0], fits};
            rem_next   = fits ? diff[IV_W-1:0] : trial[IV_W-1:0];
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers need no reset
    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = shift_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/tbd_accum.sv =====
// ----------------------------------------------------------------------------
// tbd_accum: open bucket accumulator
// Keeps the saturating sum, the saturating sample count and the first,
// last, minimum and maximum values of the open bucket.
// ----------------------------------------------------------------------------
module tbd_accum
    import tbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  acc_ctrl_t          ctrl,
    input  logic [VALUE_W-1:0] value,
    output acc_stat_t          stat
);

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [VALUE_W-1:0] first_reg, first_next;
    logic [VALUE_W-1:0] last_reg, last_next;
    logic [VALUE_W-1:0] min_reg, min_next;
    logic [VALUE_W-1:0] max_reg, max_next;

    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;

    // Add with one guard bit, clamp at the signed bounds
    assign sum_wide = {sum_reg[SUM_W-1], sum_reg}
                    + {{(SUM_W+1-VALUE_W){value[VALUE_W-1]}}, value};

    always_comb begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        first_next = first_reg;
        last_next  = last_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (ctrl.clear) begin
            sum_next   = '0;
            count_next = '0;
        end else if (ctrl.add) begin
            sum_next  = sum_sat;
            last_next = value;
            if (count_reg == '0) begin
                first_next = value;
                min_next   = value;
                max_next   = value;
            end else begin
                if ($signed(value) < $signed(min_reg)) begin
                    min_next = value;
                end
                if ($signed(value) > $signed(max_reg)) begin
                    max_next = value;
                end
            end
            if (count_reg != COUNT_MAX) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    // Value trackers are only read once the count is nonzero
    always_ff @(posedge aclk) begin
        first_reg <= first_next;
        last_reg  <= last_next;
        min_reg   <= min_next;
        max_reg   <= max_next;
    end

    assign stat.sum      = sum_reg;
    assign stat.count    = count_reg;
    assign stat.head_val = first_reg;
    assign stat.tail_val = last_reg;
    assign stat.min_val  = min_reg;
    assign stat.max_val  = max_reg;

endmodule

// ===== rtl/time_bucket_downsampler_core.sv =====
// ----------------------------------------------------------------------------
// time_bucket_downsampler_core: tumbling time bucket aggregation
// Groups timestamped samples into aligned buckets and emits one aggregate
// per closed bucket.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one sample per transfer: time and value in s_tdata,
//   end-of-sequence mark in s_tlast. m_ channel carries one closed bucket per
//   transfer: start time, aggregate and bucket ordinal in m_tdata; m_tlast is
//   set on the last bucket that a sample produced. cfg_ writes the interval,
//   the aggregate selector and the output limit, and is always ready.
// Sequencing: one sample at a time. A sample that joins the open bucket
//   passes check and add. Opening a bucket adds the alignment modulo on the
//   serial divider. Each emitted average adds another division; other
//   aggregates skip the divider. A final sample adds one clearing step.
//   Any output stall holds the core in the load state. The bit-serial
//   divider is shared by the modulo and the average.
// Output: an emitted bucket passes the emit state, the divider wait for an
//   average, then the load state, which writes the output register.
// Reset: clears the bucket state and restores the register defaults; no
//   clearing pass. A stalled m_ holds its transfer in the output register;
//   the core waits there before loading another result.
// ----------------------------------------------------------------------------
module time_bucket_downsampler_core
    import tbd_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    // sample_time [47:0], sample_value [79:48]
    input  logic [79:0]    s_tdata,
    input  logic           s_tlast,
    input  logic           s_tvalid,
    output logic           s_tready,
    // bucket_time [47:0], aggregate_value [103:48], bucket_index [119:104]
    output logic [119:0]   m_tdata,
    output logic           m_tlast,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_EMIT  = 4'd2;
    localparam logic [3:0] S_DIVW  = 4'd3;
    localparam logic [3:0] S_LOAD  = 4'd4;
    localparam logic [3:0] S_MOD   = 4'd5;
    localparam logic [3:0] S_MODW  = 4'd6;
    localparam logic [3:0] S_LIM   = 4'd7;
    localparam logic [3:0] S_ADD   = 4'd8;
    localparam logic [3:0] S_CLEAR = 4'd9;

    logic [3:0]          state_reg, state_next;

    // Configuration
    logic [IV_W-1:0]     interval_reg;
    logic [FUNC_W-1:0]   func_reg;
    logic [INDEX_W-1:0]  max_out_reg;

    // Held sample
    logic [TIME_W-1:0]   t_reg, t_next;
    logic [VALUE_W-1:0]  v_reg, v_next;
    logic                fin_reg, fin_next;

    // Sequence state
    logic                open_reg, open_next;
    logic [TIME_W-1:0]   start_reg, start_next;
    logic [TIME_W:0]     limit_reg, limit_next;
    logic [EMIT_W-1:0]   emitted_reg, emitted_next;
    logic                emit_sel_reg, emit_sel_next;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic [TIME_W-1:0]   m_time_reg, m_time_next;
    logic [SUM_W-1:0]    m_agg_reg, m_agg_next;
    logic [INDEX_W-1:0]  m_idx_reg, m_idx_next;
    logic                m_last_reg, m_last_next;

    // Submodule links
    acc_ctrl_t           acc_ctrl;
    acc_stat_t           acc_stat;
    logic                div_start;
    logic [SUM_W-1:0]    div_dividend;
    logic [IV_W-1:0]     div_divisor;
    logic                div_busy;
    logic                div_done;
    logic [SUM_W-1:0]    div_quot;
    logic [IV_W-1:0]     div_rem;

    logic [IV_W-1:0]     iv;
    logic                is_avg;
    logic                sum_neg;
    logic [SUM_W-1:0]    sum_mag;
    logic [SUM_W-1:0]    agg_value;
    logic                can_emit;
    logic                closes;
    logic                out_free;
    logic                out_load;
    logic [EMIT_W-1:0]   emitted_inc;

    assign iv       = (interval_reg == '0) ? IV_W'(1) : interval_reg;
    assign is_avg   = (func_reg == AGG_AVG) || (func_reg > AGG_COUNT);
    assign sum_neg  = acc_stat.sum[SUM_W-1];
    assign sum_mag  = sum_neg ? (~acc_stat.sum + 1'b1) : acc_stat.sum;
    assign can_emit = (emitted_reg < {1'b0, max_out_reg}) && (acc_stat.count != '0);
    assign closes   = open_reg && ({1'b0, t_reg} >= limit_reg);
    assign out_free = !m_valid_reg || m_tready;
    assign emitted_inc = emitted_reg + 1'b1;

    // Select the aggregate of the open bucket
    always_comb begin
        case (func_reg)
            AGG_MIN:   agg_value = SUM_W'($signed(acc_stat.min_val));
            AGG_MAX:   agg_value = SUM_W'($signed(acc_stat.max_val));
            AGG_SUM:   agg_value = acc_stat.sum;
            AGG_FIRST: agg_value = SUM_W'($signed(acc_stat.head_val));
            AGG_LAST:  agg_value = SUM_W'($signed(acc_stat.tail_val));
            AGG_COUNT: agg_value = SUM_W'(acc_stat.count);
            default:   agg_value = sum_neg ? (~div_quot + 1'b1) : div_quot;
        endcase
    end

    // Divider operands: alignment modulo when opening, else the average
    always_comb begin
        if (state_reg == S_MOD) begin
            div_dividend = SUM_W'(t_reg);
            div_divisor  = iv;
        end else begin
            div_dividend = sum_mag;
            div_divisor  = IV_W'(acc_stat.count);
        end
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        t_next        = t_reg;
        v_next        = v_reg;
        fin_next      = fin_reg;
        open_next     = open_reg;
        start_next    = start_reg;
        limit_next    = limit_reg;
        emitted_next  = emitted_reg;
        emit_sel_next = emit_sel_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_time_next   = m_time_reg;
        m_agg_next    = m_agg_reg;
        m_idx_next    = m_idx_reg;
        m_last_next   = m_last_reg;
        acc_ctrl      = '0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    t_next     = s_tdata[TIME_W-1:0];
                    v_next     = s_tdata[TIME_W+VALUE_W-1:TIME_W];
                    fin_next   = s_tlast;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (closes && can_emit) begin
                    emit_sel_next = 1'b0;
                    state_next    = S_EMIT;
                end else if (!open_reg || closes) begin
                    state_next = S_MOD;
                end else begin
                    state_next = S_ADD;
                end
            end
            S_EMIT: begin
                if (is_avg) begin
                    div_start  = 1'b1;
                    state_next = S_DIVW;
                end else begin
                    state_next = S_LOAD;
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                // Hold until the output register is free
                if (out_free) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    m_time_next  = start_reg;
                    m_agg_next   = agg_value;
                    m_idx_next   = emitted_reg[INDEX_W-1:0];
                    m_last_next  = emit_sel_reg ||
                                   !(fin_reg && (emitted_inc < {1'b0, max_out_reg}));
                    emitted_next = emitted_inc;
                    state_next   = emit_sel_reg ? S_CLEAR : S_MOD;
                end
            end
            S_MOD: begin
                div_start  = 1'b1;
                state_next = S_MODW;
            end
            S_MODW: begin
                if (div_done) begin
                    start_next = t_reg - TIME_W'(div_rem);
                    state_next = S_LIM;
                end
            end
            S_LIM: begin
                limit_next     = {1'b0, start_reg} + (TIME_W+1)'(iv);
                open_next      = 1'b1;
                acc_ctrl.clear = 1'b1;
                state_next     = S_ADD;
            end
            S_ADD: begin
                acc_ctrl.add = 1'b1;
                if (!fin_reg) begin
                    state_next = S_IDLE;
                end else if (emitted_reg < {1'b0, max_out_reg}) begin
                    emit_sel_next = 1'b1;
                    state_next    = S_EMIT;
                end else begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR: begin
                open_next      = 1'b0;
                emitted_next   = '0;
                acc_ctrl.clear = 1'b1;
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            open_reg     <= 1'b0;
            start_reg    <= '0;
            limit_reg    <= '0;
            emitted_reg  <= '0;
            emit_sel_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            interval_reg <= INTERVAL_RESET;
            func_reg     <= AGG_AVG;
            max_out_reg  <= MAX_OUT_RESET;
        end else begin
            state_reg    <= state_next;
            open_reg     <= open_next;
            start_reg    <= start_next;
            limit_reg    <= limit_next;
            emitted_reg  <= emitted_next;
            emit_sel_reg <= emit_sel_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_INTERVAL: interval_reg <= cfg_data;
                    REG_FUNC:     func_reg     <= cfg_data[FUNC_W-1:0];
                    REG_MAX_OUT:  max_out_reg  <= cfg_data[INDEX_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        t_reg      <= t_next;
        v_reg      <= v_next;
        fin_reg    <= fin_next;
        m_time_reg <= m_time_next;
        m_agg_reg  <= m_agg_next;
        m_idx_reg  <= m_idx_next;
        m_last_reg <= m_last_next;
    end

    tbd_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (acc_ctrl),
        .value   (v_reg),
        .stat    (acc_stat)
    );

    tbd_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tlast   = m_last_reg;
    assign m_tdata   = {m_idx_reg, m_agg_reg, m_time_reg};

    // Divider is never restarted mid-operation
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // No sample is taken while a division is running
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy)
        else $error("sample accepted during division");

    // A result is loaded only into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("output register overwritten");

    // An open bucket between samples always holds at least one sample
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && open_reg) |-> (acc_stat.count != '0))
        else $error("open bucket with no samples");

endmodule
